// ----- hw/rtl/cbmb_pkg.sv -----
// Shared types and constants for the camera basis matrix builder.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package cbmb_pkg;

    // Vector slots inside the normalizer word.
    localparam int VEC_RIGHT = 0;
    localparam int VEC_UP    = 1;
    localparam int VEC_FWD   = 2;

    // Row number of the constant bottom row of the matrix.
    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef logic [1:0] row_idx_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cbmb_front.sv -----
// Front stages: forward vector, cross-product terms and the right vector.
// Depends on cbmb_pkg; feeds cbmb_norm.
`default_nettype none

module cbmb_front
    import cbmb_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    en,
    input  wire logic                                    in_valid,
    input  wire logic [2:0][WORD_WIDTH-1:0]              in_pos,
    input  wire logic [2:0][WORD_WIDTH-1:0]              in_focus,
    input  wire logic [2:0][WORD_WIDTH-1:0]              in_up,
    output logic                                         out_valid,
    output logic [2:0][2:0][2*WORD_WIDTH+1:0]            out_vec,
    output logic [2:0][WORD_WIDTH-1:0]                   out_pos
);

    localparam int W  = WORD_WIDTH;
    localparam int VW = 2 * W + 2;

    logic [2:0] vld_reg;

    logic signed [W:0]     fwd1_reg [3];
    logic signed [W-1:0]   up1_reg  [3];
    logic [2:0][W-1:0]     pos1_reg;

    logic signed [2*W:0]   p2_reg   [3];
    logic signed [2*W:0]   q2_reg   [3];
    logic signed [W:0]     fwd2_reg [3];
    logic signed [W-1:0]   up2_reg  [3];
    logic [2:0][W-1:0]     pos2_reg;

    logic [2:0][2:0][VW-1:0] vec3_reg;
    logic [2:0][W-1:0]       pos3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                fwd1_reg[i] <= $signed({in_focus[i][W-1], in_focus[i]})
                             - $signed({in_pos[i][W-1], in_pos[i]});
                up1_reg[i]  <= $signed(in_up[i]);
            end
            pos1_reg <= in_pos;

            // right[i] = fwd[i+1] * up[i+2] - fwd[i+2] * up[i+1], indices mod 3
            p2_reg[0] <= (2*W+1)'(fwd1_reg[1]) * (2*W+1)'(up1_reg[2]);
            q2_reg[0] <= (2*W+1)'(fwd1_reg[2]) * (2*W+1)'(up1_reg[1]);
            p2_reg[1] <= (2*W+1)'(fwd1_reg[2]) * (2*W+1)'(up1_reg[0]);
            q2_reg[1] <= (2*W+1)'(fwd1_reg[0]) * (2*W+1)'(up1_reg[2]);
            p2_reg[2] <= (2*W+1)'(fwd1_reg[0]) * (2*W+1)'(up1_reg[1]);
            q2_reg[2] <= (2*W+1)'(fwd1_reg[1]) * (2*W+1)'(up1_reg[0]);
            for (int i = 0; i < 3; i++) begin
                fwd2_reg[i] <= fwd1_reg[i];
                up2_reg[i]  <= up1_reg[i];
            end
            pos2_reg <= pos1_reg;

            for (int i = 0; i < 3; i++) begin
                vec3_reg[VEC_RIGHT][i] <= VW'(VW'(p2_reg[i]) - VW'(q2_reg[i]));
                vec3_reg[VEC_UP][i]    <= VW'(up2_reg[i]);
                vec3_reg[VEC_FWD][i]   <= VW'(fwd2_reg[i]);
            end
            pos3_reg <= pos2_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_vec   = vec3_reg;
    assign out_pos   = pos3_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/cbmb_norm.sv -----
// Normalizer for the right, up and forward vectors: sum of squares,
// a pipelined square root (one bit per stage) and pipelined dividers.
// Depends on cbmb_pkg; sits between cbmb_front and cbmb_rows.
`default_nettype none

module cbmb_norm
    import cbmb_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    en,
    input  wire logic                                    in_valid,
    input  wire logic [2:0][2:0][2*WORD_WIDTH+1:0]       in_vec,
    input  wire logic [2:0][WORD_WIDTH-1:0]              in_pos,
    output logic                                         out_valid,
    output logic [2:0][2:0][WORD_WIDTH-1:0]              out_vec,
    output logic [2:0][WORD_WIDTH-1:0]                   out_pos
);

    localparam int W  = WORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int VW = 2 * W + 2;
    localparam int H  = (VW + 1) / 2;
    localparam int L  = VW - H;
    localparam int SW = 2 * VW + 2;
    localparam int XW = SW + 2 * F;
    localparam int RB = (XW + 1) / 2;
    localparam int RW = 2 * RB + 1;
    localparam int QB = F + 2;
    localparam int DW = VW + 2 * F + 3;
    localparam int CW = QB + W + 1;
    localparam int NS = RB + QB + 5;

    logic                vld_reg [NS];
    logic [2:0][W-1:0]   pos_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NS; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg[0] <= in_pos;
            for (int k = 1; k < NS; k++) pos_reg[k] <= pos_reg[k-1];
        end
    end

    // Stage 1: sign and magnitude.
    logic [VW-1:0] mag1_reg [3][3];
    logic          neg1_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                for (int i = 0; i < 3; i++) begin
                    neg1_reg[v][i] <= in_vec[v][i][VW-1];
                    mag1_reg[v][i] <= in_vec[v][i][VW-1] ? (~in_vec[v][i] + VW'(1))
                                                         : in_vec[v][i];
                end
            end
        end
    end

    // Stage 2: partial products of each square, split into halves.
    logic [2*H-1:0] hh2_reg  [3][3];
    logic [H+L-1:0] hl2_reg  [3][3];
    logic [2*L-1:0] ll2_reg  [3][3];
    logic [VW-1:0]  mag2_reg [3][3];
    logic           neg2_reg [3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                for (int i = 0; i < 3; i++) begin
                    hh2_reg[v][i] <= (2*H)'(mag1_reg[v][i][VW-1:L])
                                   * (2*H)'(mag1_reg[v][i][VW-1:L]);
                    hl2_reg[v][i] <= (H+L)'(mag1_reg[v][i][VW-1:L])
                                   * (H+L)'(mag1_reg[v][i][L-1:0]);
                    ll2_reg[v][i] <= (2*L)'(mag1_reg[v][i][L-1:0])
                                   * (2*L)'(mag1_reg[v][i][L-1:0]);
                    mag2_reg[v][i] <= mag1_reg[v][i];
                    neg2_reg[v][i] <= neg1_reg[v][i];
                end
            end
        end
    end

    // Square root pipeline; index 0 holds the scaled squared length.
    logic [RW-1:0] sx_reg   [RB+1][3];
    logic [RW-1:0] sr_reg   [RB+1][3];
    logic          sz_reg   [RB+1][3];
    logic [VW-1:0] smag_reg [RB+1][3][3];
    logic          sneg_reg [RB+1][3][3];

    logic [SW-1:0] sum_c [3];

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            sum_c[v] = '0;
            for (int i = 0; i < 3; i++) begin
                sum_c[v] = sum_c[v] + (SW'(hh2_reg[v][i]) << (2 * L))
                                    + (SW'(hl2_reg[v][i]) << (L + 1))
                                    + SW'(ll2_reg[v][i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                sx_reg[0][v] <= RW'(sum_c[v]) << (2 * F);
                sr_reg[0][v] <= '0;
                sz_reg[0][v] <= (sum_c[v] == '0);
                for (int i = 0; i < 3; i++) begin
                    smag_reg[0][v][i] <= mag2_reg[v][i];
                    sneg_reg[0][v][i] <= neg2_reg[v][i];
                end
            end
        end
    end

    for (genvar j = 0; j < RB; j++) begin : g_sqrt
        localparam logic [RW-1:0] SQ_BIT = RW'(1) << (2 * (RB - 1 - j));
        logic [RW-1:0] t_c [3];

        always_comb begin
            for (int v = 0; v < 3; v++) t_c[v] = sr_reg[j][v] + SQ_BIT;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int v = 0; v < 3; v++) begin
                    if (sx_reg[j][v] >= t_c[v]) begin
                        sx_reg[j+1][v] <= sx_reg[j][v] - t_c[v];
                        sr_reg[j+1][v] <= (sr_reg[j][v] >> 1) + SQ_BIT;
                    end else begin
                        sx_reg[j+1][v] <= sx_reg[j][v];
                        sr_reg[j+1][v] <= sr_reg[j][v] >> 1;
                    end
                    sz_reg[j+1][v] <= sz_reg[j][v];
                    for (int i = 0; i < 3; i++) begin
                        smag_reg[j+1][v][i] <= smag_reg[j][v][i];
                        sneg_reg[j+1][v][i] <= sneg_reg[j][v][i];
                    end
                end
            end
        end
    end

    // Restoring division, one quotient bit per stage, MSB first.
    // The quotient of a component by the root never reaches 2^(F+2).
    logic [RB-1:0] dm_reg   [QB+1][3];
    logic          dz_reg   [QB+1][3];
    logic [DW-1:0] drem_reg [QB+1][3][3];
    logic [QB-1:0] dq_reg   [QB+1][3][3];
    logic          dneg_reg [QB+1][3][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 3; v++) begin
                dm_reg[0][v] <= sr_reg[RB][v][RB-1:0];
                dz_reg[0][v] <= sz_reg[RB][v];
                for (int i = 0; i < 3; i++) begin
                    drem_reg[0][v][i] <= DW'(smag_reg[RB][v][i]) << (2 * F);
                    dq_reg[0][v][i]   <= '0;
                    dneg_reg[0][v][i] <= sneg_reg[RB][v][i];
                end
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int KK = QB - 1 - j;
        logic [DW-1:0] dd_c [3];

        always_comb begin
            for (int v = 0; v < 3; v++) dd_c[v] = DW'(dm_reg[j][v]) << KK;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int v = 0; v < 3; v++) begin
                    dm_reg[j+1][v] <= dm_reg[j][v];
                    dz_reg[j+1][v] <= dz_reg[j][v];
                    for (int i = 0; i < 3; i++) begin
                        if (drem_reg[j][v][i] >= dd_c[v]) begin
                            drem_reg[j+1][v][i] <= drem_reg[j][v][i] - dd_c[v];
                            dq_reg[j+1][v][i]   <= dq_reg[j][v][i] | (QB'(1) << KK);
                        end else begin
                            drem_reg[j+1][v][i] <= drem_reg[j][v][i];
                            dq_reg[j+1][v][i]   <= dq_reg[j][v][i];
                        end
                        dneg_reg[j+1][v][i] <= dneg_reg[j][v][i];
                    end
                end
            end
        end
    end

    // Final stage: saturate, restore the sign, force zero-length vectors to 0.
    logic [2:0][2:0][W-1:0] sat_c;
    logic [2:0][2:0][W-1:0] res_reg;

    always_comb begin
        logic [CW-1:0] qe;
        logic [CW-1:0] lim;
        logic [CW-1:0] val;
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
                qe  = CW'(dq_reg[QB][v][i]);
                lim = dneg_reg[QB][v][i] ? (CW'(1) << (W - 1))
                                         : ((CW'(1) << (W - 1)) - CW'(1));
                val = (qe > lim) ? lim : qe;
                if (dz_reg[QB][v]) begin
                    sat_c[v][i] = '0;
                end else if (dneg_reg[QB][v][i]) begin
                    sat_c[v][i] = ~val[W-1:0] + W'(1);
                end else begin
                    sat_c[v][i] = val[W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) res_reg <= sat_c;
    end

    assign out_valid = vld_reg[NS-1];
    assign out_vec   = res_reg;
    assign out_pos   = pos_reg[NS-1];

endmodule

`default_nettype wire

// ----- hw/rtl/cbmb_rows.sv -----
// Row serializer: holds one finished matrix and sends it as four row words.
// Depends on cbmb_pkg; fed by cbmb_norm.
`default_nettype none

module cbmb_rows
    import cbmb_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [2:0][2:0][WORD_WIDTH-1:0]     in_vec,
    input  wire logic [2:0][WORD_WIDTH-1:0]          in_pos,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output row_idx_t                                 row_index,
    output logic [WORD_WIDTH-1:0]                    col0,
    output logic [WORD_WIDTH-1:0]                    col1,
    output logic [WORD_WIDTH-1:0]                    col2,
    output logic [WORD_WIDTH-1:0]                    col3,
    output logic                                     last_row
);

    localparam int W = WORD_WIDTH;
    localparam logic [W-1:0] ONE = (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS)
                                                      : ((W'(1) << (W - 1)) - W'(1));

    logic                   busy_reg;
    row_idx_t               cnt_reg;
    logic [2:0][2:0][W-1:0] mat_reg;
    logic [2:0][W-1:0]      pos_reg;
    logic                   load;

    // A new matrix may load in the same cycle the bottom row is taken.
    assign in_ready = !busy_reg || (m_ready && cnt_reg == ROW_LAST);
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg && m_ready) begin
            if (cnt_reg == ROW_LAST) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mat_reg <= in_vec;
            pos_reg <= in_pos;
        end
    end

    always_comb begin
        if (cnt_reg == ROW_LAST) begin
            col0 = '0;
            col1 = '0;
            col2 = '0;
            col3 = ONE;
        end else begin
            col0 = mat_reg[VEC_RIGHT][cnt_reg];
            col1 = mat_reg[VEC_UP][cnt_reg];
            col2 = mat_reg[VEC_FWD][cnt_reg];
            col3 = pos_reg[cnt_reg];
        end
    end

    assign m_valid   = busy_reg;
    assign row_index = cnt_reg;
    assign last_row  = (cnt_reg == ROW_LAST);

    a_load_starts_row0: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (m_valid && row_index == '0))
        else $error("loaded matrix does not start at the first row");

    a_drain_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_ready && cnt_reg == ROW_LAST && !in_valid) |=> !busy_reg)
        else $error("serializer stays busy after the bottom row left");

    a_hold_while_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !m_ready) |=> (busy_reg && $stable(cnt_reg)))
        else $error("row counter moved during a stall");

endmodule

`default_nettype wire

// ----- hw/rtl/camera_basis_matrix_builder.sv -----
// Look-at view matrix builder. An accepted input word passes through cbmb_front,
// cbmb_norm and cbmb_rows; RB = (4*WORD_WIDTH + 2*FRAC_BITS + 7) / 2 square-root
// stages and QB = FRAC_BITS + 2 divider stages. Four row words leave per matrix,
// which limits the input rate; the pipeline itself takes a word every cycle unless
// the row serializer stalls it. aresetn is synchronous, active low, and clears
// all valid bits and the row counter; data registers are not reset.
`default_nettype none

module camera_basis_matrix_builder
    import cbmb_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [WORD_WIDTH-1:0]  s_pos_x,
    input  wire logic signed [WORD_WIDTH-1:0]  s_pos_y,
    input  wire logic signed [WORD_WIDTH-1:0]  s_pos_z,
    input  wire logic signed [WORD_WIDTH-1:0]  s_focus_x,
    input  wire logic signed [WORD_WIDTH-1:0]  s_focus_y,
    input  wire logic signed [WORD_WIDTH-1:0]  s_focus_z,
    input  wire logic signed [WORD_WIDTH-1:0]  s_up_x,
    input  wire logic signed [WORD_WIDTH-1:0]  s_up_y,
    input  wire logic signed [WORD_WIDTH-1:0]  s_up_z,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_row_index,
    output logic signed [WORD_WIDTH-1:0]       m_col0,
    output logic signed [WORD_WIDTH-1:0]       m_col1,
    output logic signed [WORD_WIDTH-1:0]       m_col2,
    output logic signed [WORD_WIDTH-1:0]       m_col3,
    output logic                               m_last_row
);

    localparam int W  = WORD_WIDTH;
    localparam int VW = 2 * W + 2;

    logic                    en;
    logic                    front_valid;
    logic [2:0][2:0][VW-1:0] front_vec;
    logic [2:0][W-1:0]       front_pos;
    logic                    norm_valid;
    logic [2:0][2:0][W-1:0]  norm_vec;
    logic [2:0][W-1:0]       norm_pos;
    logic                    rows_ready;
    row_idx_t                row_idx;

    // The whole pipeline moves together; a bubble at the end never blocks it.
    assign en      = rows_ready || !norm_valid;
    assign s_ready = en;

    cbmb_front #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_pos    ({s_pos_z, s_pos_y, s_pos_x}),
        .in_focus  ({s_focus_z, s_focus_y, s_focus_x}),
        .in_up     ({s_up_z, s_up_y, s_up_x}),
        .out_valid (front_valid),
        .out_vec   (front_vec),
        .out_pos   (front_pos)
    );

    cbmb_norm #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_vec    (front_vec),
        .in_pos    (front_pos),
        .out_valid (norm_valid),
        .out_vec   (norm_vec),
        .out_pos   (norm_pos)
    );

    cbmb_rows #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_rows (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (norm_valid),
        .in_ready  (rows_ready),
        .in_vec    (norm_vec),
        .in_pos    (norm_pos),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .row_index (row_idx),
        .col0      (m_col0),
        .col1      (m_col1),
        .col2      (m_col2),
        .col3      (m_col3),
        .last_row  (m_last_row)
    );

    assign m_row_index = row_idx;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for camera_basis_matrix_builder: predicts the four
// look-at matrix rows of every accepted word and compares them. Uses cbmb_pkg.
`default_nettype none

module tb_top;
    import cbmb_pkg::*;

    typedef logic signed [127:0] wide_t;
    typedef logic [255:0] huge_t;
    typedef enum int {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pace_t;

    typedef struct {
        logic signed [31:0] pos [3];
        logic signed [31:0] foc [3];
        logic signed [31:0] up [3];
        pace_t pace;
    } camera_t;

    typedef struct {
        row_idx_t row;
        logic signed [31:0] c0, c1, c2, c3;
        logic last;
    } row_t;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [31:0] s_focus_x = '0, s_focus_y = '0, s_focus_z = '0;
    logic signed [31:0] s_up_x = '0, s_up_y = '0, s_up_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_row_index;
    logic signed [31:0] m_col0, m_col1, m_col2, m_col3;
    logic m_last_row;

    camera_t pending_cams [$];
    row_t expected_rows [$];
    pace_t cur_pace = PACE_FULL;
    bit word_taken = 1'b0;
    bit failed = 1'b0;
    int accepted_words = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    camera_basis_matrix_builder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_focus_x(s_focus_x), .s_focus_y(s_focus_y), .s_focus_z(s_focus_z),
        .s_up_x(s_up_x), .s_up_y(s_up_y), .s_up_z(s_up_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_row_index(m_row_index),
        .m_col0(m_col0), .m_col1(m_col1), .m_col2(m_col2), .m_col3(m_col3),
        .m_last_row(m_last_row)
    );

    function automatic huge_t int_sqrt(input huge_t s);
        huge_t r, c;
        r = '0;
        for (int b = 127; b >= 0; b--) begin
            c = r | (huge_t'(1) << b);
            if (c * c <= s) r = c;
        end
        return r;
    endfunction

    // Unit vector in Q16.16; a zero-length vector stays all zero.
    function automatic logic [95:0] unit_vector(input wide_t v0, input wide_t v1,
                                                input wide_t v2);
        wide_t v [3];
        huge_t mag [3];
        huge_t sum, root, q, lim;
        logic [95:0] res;
        v[0] = v0; v[1] = v1; v[2] = v2;
        sum = '0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = huge_t'(v[i] < 0 ? -v[i] : v[i]);
            sum += mag[i] * mag[i];
        end
        if (sum != 0) begin
            root = int_sqrt(sum << 32);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] << 32) / root;
                lim = (v[i] < 0) ? huge_t'(64'h8000_0000) : huge_t'(64'h7FFF_FFFF);
                if (q > lim) q = lim;
                res[32*i +: 32] = (v[i] < 0) ? -q[31:0] : q[31:0];
            end
        end
        return res;
    endfunction

    task automatic predict_matrix(input camera_t c);
        wide_t fwd [3];
        wide_t rgt [3];
        logic [95:0] nr, nu, nf;
        row_t r;
        for (int i = 0; i < 3; i++)
            fwd[i] = wide_t'(c.foc[i]) - wide_t'(c.pos[i]);
        for (int i = 0; i < 3; i++)
            rgt[i] = fwd[(i+1)%3] * wide_t'(c.up[(i+2)%3])
                   - fwd[(i+2)%3] * wide_t'(c.up[(i+1)%3]);
        nr = unit_vector(rgt[0], rgt[1], rgt[2]);
        nu = unit_vector(c.up[0], c.up[1], c.up[2]);
        nf = unit_vector(fwd[0], fwd[1], fwd[2]);
        for (int i = 0; i < 3; i++) begin
            r.row = row_idx_t'(i);
            r.c0 = nr[32*i +: 32];
            r.c1 = nu[32*i +: 32];
            r.c2 = nf[32*i +: 32];
            r.c3 = c.pos[i];
            r.last = 1'b0;
            expected_rows.push_back(r);
        end
        r.row = ROW_LAST;
        r.c0 = '0; r.c1 = '0; r.c2 = '0;
        r.c3 = ONE_Q16;
        r.last = 1'b1;
        expected_rows.push_back(r);
    endtask

    function automatic camera_t make_cam(input logic signed [31:0] px, py, pz,
                                         fx, fy, fz, ux, uy, uz, input pace_t p);
        camera_t c;
        c.pos[0] = px; c.pos[1] = py; c.pos[2] = pz;
        c.foc[0] = fx; c.foc[1] = fy; c.foc[2] = fz;
        c.up[0] = ux; c.up[1] = uy; c.up[2] = uz;
        c.pace = p;
        return c;
    endfunction

    function automatic logic signed [31:0] rand_word(input int shape);
        logic signed [31:0] w;
        w = $urandom;
        if (shape == 0) w = w >>> $urandom_range(31, 10);
        return w;
    endfunction

    // Input side: acceptance is seen at the rising edge, the next word goes out
    // at the falling edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            predict_matrix(make_cam(s_pos_x, s_pos_y, s_pos_z, s_focus_x, s_focus_y,
                                    s_focus_z, s_up_x, s_up_y, s_up_z, cur_pace));
            word_taken = 1'b1;
            accepted_words++;
        end
    end

    always @(negedge aclk) begin
        camera_t c;
        if (aresetn && (!s_valid || word_taken)) begin
            word_taken = 1'b0;
            if (pending_cams.size() != 0 &&
                !((pending_cams[0].pace == PACE_SRC_IDLE && $urandom_range(99) < 67) ||
                  (pending_cams[0].pace == PACE_BOTH && $urandom_range(99) < 9))) begin
                c = pending_cams.pop_front();
                cur_pace = c.pace;
                s_pos_x <= c.pos[0]; s_pos_y <= c.pos[1]; s_pos_z <= c.pos[2];
                s_focus_x <= c.foc[0]; s_focus_y <= c.foc[1]; s_focus_z <= c.foc[2];
                s_up_x <= c.up[0]; s_up_y <= c.up[1]; s_up_z <= c.up[2];
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Output side stalls; one long hold-off lets the pipeline fill up.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else if (!holdoff_done && accepted_words == 40) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            m_ready <= 1'b0;
        end else if (cur_pace == PACE_SNK_STALL) begin
            m_ready <= ($urandom_range(99) >= 67);
        end else if (cur_pace == PACE_BOTH) begin
            m_ready <= ($urandom_range(99) >= 9);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        row_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row word: row %0d cols %h %h %h %h last %b",
                         $time, m_row_index, m_col0, m_col1, m_col2, m_col3, m_last_row);
                failed = 1'b1;
            end else begin
                e = expected_rows.pop_front();
                if (m_row_index !== e.row || m_col0 !== e.c0 || m_col1 !== e.c1 ||
                    m_col2 !== e.c2 || m_col3 !== e.c3 || m_last_row !== e.last) begin
                    $display("%0t: row mismatch: expected row %0d %h %h %h %h last %b",
                             $time, e.row, e.c0, e.c1, e.c2, e.c3, e.last);
                    $display("%0t:                 actual row %0d %h %h %h %h last %b",
                             $time, m_row_index, m_col0, m_col1, m_col2, m_col3,
                             m_last_row);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** camera_basis_matrix_builder: FAILED **");
            $finish;
        end
    end

    initial begin
        logic signed [31:0] mx, mn, px, py, pz, ux, uy, uz;
        pace_t p;
        int shape;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        // Plain camera, extremes, focus on the camera, zero up, up along forward.
        pending_cams.push_back(make_cam(0, 0, 32'sh50000, 0, 0, 0, 0, ONE_Q16, 0,
                                        PACE_FULL));
        pending_cams.push_back(make_cam(mn, mn, mn, mx, mx, mx, mx, mn, mx, PACE_FULL));
        pending_cams.push_back(make_cam(mx, mx, mx, mn, mn, mn, mn, mx, mn, PACE_FULL));
        pending_cams.push_back(make_cam(mx, mn, mx, mn, mx, mn, mn, mn, mn, PACE_FULL));
        pending_cams.push_back(make_cam(7, -9, 11, 7, -9, 11, 0, ONE_Q16, 0, PACE_FULL));
        pending_cams.push_back(make_cam(1, 2, 3, 4, 5, 6, 0, 0, 0, PACE_FULL));
        pending_cams.push_back(make_cam(0, 0, 0, 0, 0, 0, 0, 0, 0, PACE_FULL));
        pending_cams.push_back(make_cam(0, 0, 0, ONE_Q16, 0, 0, 3 * ONE_Q16, 0, 0,
                                        PACE_FULL));
        pending_cams.push_back(make_cam(0, 0, 0, 0, 0, 1, 0, 1, 0, PACE_FULL));
        pending_cams.push_back(make_cam(-1, -1, -1, 0, 0, 0, 1, 0, 0, PACE_FULL));
        pending_cams.push_back(make_cam(0, 0, 0, mx, 0, 0, 0, mn, 0, PACE_FULL));
        pending_cams.push_back(make_cam(mn, 0, 0, mx, 0, 0, 0, 0, mx, PACE_FULL));
        for (int n = 0; n < 320; n++) begin
            p = pace_t'(n / 80);
            shape = $urandom_range(9) < 6 ? 0 : 1;
            px = rand_word(shape); py = rand_word(shape); pz = rand_word(shape);
            ux = rand_word(shape); uy = rand_word(shape); uz = rand_word(shape);
            if ($urandom_range(9) == 0) begin
                // Up parallel to forward: the right vector collapses to zero.
                px = px >>> 2; py = py >>> 2; pz = pz >>> 2;
                ux = ux >>> 2; uy = uy >>> 2; uz = uz >>> 2;
                pending_cams.push_back(make_cam(px, py, pz, px + ux, py + uy, pz + uz,
                                                ux, uy, uz, p));
            end else begin
                pending_cams.push_back(make_cam(px, py, pz, rand_word(shape),
                                                rand_word(shape), rand_word(shape),
                                                ux, uy, uz, p));
            end
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_cams.size() != 0 || s_valid || expected_rows.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (!failed)
            $display("** camera_basis_matrix_builder: PASSED **");
        else
            $display("** camera_basis_matrix_builder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/cbmb_pkg.sv
hw/rtl/cbmb_front.sv
hw/rtl/cbmb_norm.sv
hw/rtl/cbmb_rows.sv
hw/rtl/camera_basis_matrix_builder.sv
tb/sv/tb_top.sv
